### hdl/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared constants and types of the grid maze reachability block.
// ----------------------------------------------------------------------------
package gmr_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [2:0] DIR_DOWN  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_END   = 3'd4;

    typedef struct packed {
        logic wall_we;
        logic wall_bit;
        logic visit_we;
        logic visit_bit;
    } map_wr_t;

endpackage

### hdl/gmr_map_mem.sv
// ----------------------------------------------------------------------------
// gmr_map_mem
// Wall map and visited map, one bit per cell, sharing one write address and
// one read address, with registered read data.
// ----------------------------------------------------------------------------
module gmr_map_mem #(
    parameter int AW = 8
) (
    input  logic              aclk,
    input  gmr_pkg::map_wr_t  wr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [AW-1:0]     rd_addr,
    output logic              wall_q,
    output logic              visit_q
);

    localparam int DEPTH = 1 << AW;

    logic wall_mem  [DEPTH];
    logic visit_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.wall_we) begin
            wall_mem[wr_addr] <= wr.wall_bit;
        end
        if (wr.visit_we) begin
            visit_mem[wr_addr] <= wr.visit_bit;
        end
        wall_q  <= wall_mem[rd_addr];
        visit_q <= visit_mem[rd_addr];
    end

endmodule

### hdl/gmr_stack_mem.sv
// ----------------------------------------------------------------------------
// gmr_stack_mem
// Search stack storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module gmr_stack_mem #(
    parameter int DEPTH = 256,
    parameter int IW    = 8,
    parameter int DW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/grid_maze_reachability_top.sv
// ----------------------------------------------------------------------------
// grid_maze_reachability_top
// Depth-first reachability search over a ROWS x COLS wall map.
//
// The input stream carries one word per item. s_tuser selects the item kind:
// 0 writes one wall map cell, 1 starts a search from the given cell. A write
// gives no output word. A search gives one output word whose bit 0 is 1 when
// the bottom-right cell is reachable from the start. Writes or starts outside
// the grid change nothing; such a start reports 0. A search first sweeps the
// visited map, one cell per cycle, then seeds the stack and, for each popped
// cell, does one stack read, one load, and four neighbor probes through the
// map memory read port plus one final check. After reset the block sweeps
// both maps with s_tready low. A finished result waits in the output
// register; the block keeps accepting map writes and a new search while
// m_tready is low, and holds a later result until the earlier word has been
// taken.
// ----------------------------------------------------------------------------
module grid_maze_reachability_top #(
    parameter int ROWS = gmr_pkg::ROWS_DEF,
    parameter int COLS = gmr_pkg::COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from low: row[3:0], col[7:4], wall[8], zero fill.
    input  logic [gmr_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from low: operation[0].
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from low: path_found[0], zero fill.
    output logic [gmr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int CELLS = ROWS * COLS;
    localparam int SIW   = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_POP   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;
    localparam logic [2:0] ST_PROBE = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [2:0]      dir_reg, dir_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   nb_addr_reg, nb_addr_next;
    logic [RW-1:0]   start_row_reg, start_row_next;
    logic [CW-1:0]   start_col_reg, start_col_next;
    logic            found_reg, found_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            m_found_reg, m_found_next;

    logic [3:0]      in_row;
    logic [3:0]      in_col;
    logic            in_wall;
    logic            in_inside;
    logic            s_acc;

    gmr_pkg::map_wr_t map_wr;
    logic [AW-1:0]   map_wr_addr;
    logic            wall_q;
    logic            visit_q;

    logic            stk_we;
    logic [SIW-1:0]  stk_waddr;
    logic [AW-1:0]   stk_wdata;
    logic [SIW-1:0]  stk_raddr;
    logic [AW-1:0]   stk_rdata;
    logic [CNTW-1:0] cnt_m1;

    logic            nb_ok;
    logic [RW-1:0]   nb_row;
    logic [CW-1:0]   nb_col;
    logic [AW-1:0]   nb_addr;
    logic [RW-1:0]   pop_row;
    logic [CW-1:0]   pop_col;
    logic            push_ok;

    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_wall   = s_tdata[8];
    assign in_inside = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gmr_pkg::M_TDATA_W-1){1'b0}}, m_found_reg};

    assign cnt_m1    = cnt_reg - CNTW'(1);
    assign stk_raddr = cnt_m1[SIW-1:0];
    assign pop_row   = stk_rdata[AW-1:CW];
    assign pop_col   = stk_rdata[CW-1:0];
    assign push_ok   = pend_reg && !wall_q && !visit_q && (cnt_reg != CNTW'(CELLS));

    always_comb begin
        nb_ok  = 1'b0;
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        unique case (dir_reg)
            gmr_pkg::DIR_DOWN: begin
                nb_ok  = (cur_row_reg != RW'(ROWS - 1));
                nb_row = cur_row_reg + RW'(1);
            end
            gmr_pkg::DIR_RIGHT: begin
                nb_ok  = (cur_col_reg != CW'(COLS - 1));
                nb_col = cur_col_reg + CW'(1);
            end
            gmr_pkg::DIR_UP: begin
                nb_ok  = (cur_row_reg != '0);
                nb_row = cur_row_reg - RW'(1);
            end
            gmr_pkg::DIR_LEFT: begin
                nb_ok  = (cur_col_reg != '0);
                nb_col = cur_col_reg - CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
        nb_addr = {nb_row, nb_col};
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        dir_next       = dir_reg;
        pend_next      = pend_reg;
        nb_addr_next   = nb_addr_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        found_next     = found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_found_next   = m_found_reg;
        map_wr         = '0;
        map_wr_addr    = clr_cnt_reg;
        stk_we         = 1'b0;
        stk_waddr      = cnt_reg[SIW-1:0];
        stk_wdata      = nb_addr_reg;

        unique case (state_reg)
            ST_INIT: begin
                map_wr.wall_we  = 1'b1;
                map_wr.visit_we = 1'b1;
                clr_cnt_next    = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                map_wr_addr = {RW'(in_row), CW'(in_col)};
                if (s_acc) begin
                    if (s_tuser[0] == gmr_pkg::OP_WRITE) begin
                        map_wr.wall_we  = in_inside;
                        map_wr.wall_bit = in_wall;
                    end else if (in_inside) begin
                        start_row_next = RW'(in_row);
                        start_col_next = CW'(in_col);
                        state_next     = ST_CLEAR;
                    end else begin
                        found_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                map_wr.visit_we = 1'b1;
                clr_cnt_next    = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                map_wr_addr      = {start_row_reg, start_col_reg};
                map_wr.visit_we  = 1'b1;
                map_wr.visit_bit = 1'b1;
                stk_we           = 1'b1;
                stk_waddr        = '0;
                stk_wdata        = {start_row_reg, start_col_reg};
                cnt_next         = CNTW'(1);
                state_next       = ST_POP;
            end
            ST_POP: begin
                if (cnt_reg == '0) begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next   = cnt_m1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cur_row_next = pop_row;
                cur_col_next = pop_col;
                dir_next     = gmr_pkg::DIR_DOWN;
                pend_next    = 1'b0;
                if (pop_row == RW'(ROWS - 1) && pop_col == CW'(COLS - 1)) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                map_wr_addr = nb_addr_reg;
                if (push_ok) begin
                    map_wr.visit_we  = 1'b1;
                    map_wr.visit_bit = 1'b1;
                    stk_we           = 1'b1;
                    cnt_next         = cnt_reg + CNTW'(1);
                end
                if (dir_reg == gmr_pkg::DIR_END) begin
                    pend_next  = 1'b0;
                    state_next = ST_POP;
                end else begin
                    pend_next    = nb_ok;
                    nb_addr_next = nb_addr;
                    dir_next     = dir_reg + 3'd1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_cnt_reg  <= '0;
            cnt_reg      <= '0;
            dir_reg      <= gmr_pkg::DIR_DOWN;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cnt_reg      <= cnt_next;
            dir_reg      <= dir_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        nb_addr_reg   <= nb_addr_next;
        start_row_reg <= start_row_next;
        start_col_reg <= start_col_next;
        found_reg     <= found_next;
        m_found_reg   <= m_found_next;
    end

    gmr_map_mem #(
        .AW(AW)
    ) u_map_mem (
        .aclk    (aclk),
        .wr      (map_wr),
        .wr_addr (map_wr_addr),
        .rd_addr (nb_addr),
        .wall_q  (wall_q),
        .visit_q (visit_q)
    );

    gmr_stack_mem #(
        .DEPTH(CELLS),
        .IW   (SIW),
        .DW   (AW)
    ) u_stack_mem (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule
